@@ hw/rtl/ncr_pkg.sv @@
`default_nettype none

package ncr_pkg;

   // Table sizes.
   localparam int MAX_CENTROIDS = 64;
   localparam int DIM           = 32;

   // Field widths of the ports.
   localparam int CIDX_W  = 6;
   localparam int DIMX_W  = 5;
   localparam int VALUE_W = 16;
   localparam int RES_W   = 17;
   localparam int DOC_W   = 16;
   localparam int CFG_W   = 7;

   // Internal widths derived from the table sizes.
   localparam int K_W         = $clog2(MAX_CENTROIDS);
   localparam int J_W         = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int CNT_W       = $clog2(MAX_CENTROIDS + 1);
   localparam int STORE_DEPTH = MAX_CENTROIDS * DIM;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Arithmetic widths: Q2.30 products, norms and scores with 31 fraction bits.
   localparam int PROD_W = 2 * VALUE_W;
   localparam int NORM_W = 40;
   localparam int ACC_W  = NORM_W - 1;

   // Command codes.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_EMBED = 1'b1;

   // Decoded work for the back end.
   typedef struct packed {
      logic                       load;
      logic                       buf_wr;
      logic                       score;
      logic                       eod;
      logic [K_W-1:0]             cidx;
      logic [J_W-1:0]             didx;
      logic signed [VALUE_W-1:0]  value;
   } job_type;

endpackage

`default_nettype wire

@@ hw/rtl/ncr_front.sv @@
`default_nettype none

module ncr_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_command,
   input  wire logic [ncr_pkg::CIDX_W-1:0]         req_centroid_index,
   input  wire logic [ncr_pkg::DIMX_W-1:0]         req_dim_index,
   input  wire logic signed [ncr_pkg::VALUE_W-1:0] req_value,
   input  wire logic                               req_last_element,
   input  wire logic                               req_end_of_document,
   output logic                                    job_valid,
   output ncr_pkg::job_type                        job,
   input  wire logic                               job_pop
);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   ncr_pkg::job_type     queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QCNT_W-1:0]    count_ff;
   ncr_pkg::job_type     new_job;
   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 cidx_ok;
   logic                 dim_ok;
   logic                 is_embed;

   // Classify the item: out-of-range loads and idle embedding elements carry no work.
   always_comb begin
      cidx_ok         = 32'(req_centroid_index) < ncr_pkg::MAX_CENTROIDS;
      dim_ok          = 32'(req_dim_index) < ncr_pkg::DIM;
      is_embed        = (req_command == ncr_pkg::CMD_EMBED);
      new_job.load    = (req_command == ncr_pkg::CMD_LOAD) && cidx_ok && dim_ok;
      new_job.buf_wr  = is_embed && dim_ok;
      new_job.score   = is_embed && req_last_element;
      new_job.eod     = is_embed && req_last_element && req_end_of_document;
      new_job.cidx    = ncr_pkg::K_W'(req_centroid_index);
      new_job.didx    = ncr_pkg::J_W'(req_dim_index);
      new_job.value   = req_value;
   end

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = start && !busy;
   assign push      = accept && (new_job.load || new_job.buf_wr || new_job.score);
   assign job_valid = (count_ff != '0);
   assign pop       = job_pop && job_valid;
   assign job       = queue_ff[rd_ptr_ff];

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ncr_back.sv @@
`default_nettype none

module ncr_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              job_valid,
   input  wire ncr_pkg::job_type                  job,
   output logic                                   job_pop,
   input  wire logic [ncr_pkg::CFG_W-1:0]         centroids_in_use,
   output logic                                   rsp_strobe,
   output logic [ncr_pkg::CIDX_W-1:0]             rsp_cluster_id,
   output logic [ncr_pkg::DIMX_W-1:0]             rsp_residual_index,
   output logic signed [ncr_pkg::RES_W-1:0]       rsp_residual_value,
   output logic [ncr_pkg::DOC_W-1:0]              rsp_doc_index,
   output logic                                   rsp_last_of_run
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_WR,
      ST_SCORE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                       valid;
      logic                       first;
      logic                       last;
      logic [ncr_pkg::K_W-1:0]    k;
   } tag_type;

   typedef struct packed {
      logic                       valid;
      logic                       last;
      logic                       eod;
      logic [ncr_pkg::J_W-1:0]    j;
   } emit_tag_type;

   // Memories.
   logic signed [ncr_pkg::VALUE_W-1:0] store_mem [ncr_pkg::STORE_DEPTH];
   logic signed [ncr_pkg::NORM_W-1:0]  norm_mem  [ncr_pkg::MAX_CENTROIDS];
   logic signed [ncr_pkg::VALUE_W-1:0] emb_mem   [ncr_pkg::DIM];

   logic signed [ncr_pkg::VALUE_W-1:0] store_rd_ff;
   logic signed [ncr_pkg::NORM_W-1:0]  norm_rd_ff;
   logic signed [ncr_pkg::VALUE_W-1:0] emb_rd_ff;

   // Control state.
   state_type                          state_ff;
   state_type                          state_in;
   ncr_pkg::job_type                   job_ff;
   logic [ncr_pkg::CNT_W-1:0]          count_ff;
   logic [ncr_pkg::CNT_W-1:0]          k_ff;
   logic [ncr_pkg::J_W-1:0]            j_ff;
   logic [ncr_pkg::K_W-1:0]            best_ff;
   logic signed [ncr_pkg::NORM_W-1:0]  best_score_ff;
   logic [ncr_pkg::DOC_W-1:0]          doc_ff;
   logic signed [ncr_pkg::PROD_W-1:0]  sq_ff;

   // Scoring pipeline.
   tag_type                            t1_ff;
   tag_type                            t2_ff;
   tag_type                            t3_ff;
   tag_type                            t4_ff;
   tag_type                            t1_in;
   emit_tag_type                       e1_ff;
   emit_tag_type                       e1_in;
   logic signed [ncr_pkg::PROD_W-1:0]  prod_ff;
   logic signed [ncr_pkg::ACC_W-1:0]   acc_ff;
   logic signed [ncr_pkg::NORM_W-1:0]  norm2_ff;
   logic signed [ncr_pkg::NORM_W-1:0]  norm3_ff;
   logic signed [ncr_pkg::NORM_W-1:0]  score_ff;

   // Output registers.
   logic                               rsp_strobe_ff;
   logic [ncr_pkg::CIDX_W-1:0]         rsp_cluster_id_ff;
   logic [ncr_pkg::DIMX_W-1:0]         rsp_residual_index_ff;
   logic signed [ncr_pkg::RES_W-1:0]   rsp_residual_value_ff;
   logic [ncr_pkg::DOC_W-1:0]          rsp_doc_index_ff;
   logic                               rsp_last_of_run_ff;

   // Address and control decode.
   logic                               store_we;
   logic [ncr_pkg::STORE_AW-1:0]       store_waddr;
   logic [ncr_pkg::STORE_AW-1:0]       store_raddr;
   logic [ncr_pkg::K_W-1:0]            row;
   logic [ncr_pkg::K_W-1:0]            norm_raddr;
   logic                               norm_we;
   logic signed [ncr_pkg::NORM_W-1:0]  norm_wdata;
   logic                               emb_we;
   logic                               j_last;
   logic                               k_last;
   logic                               pipe_busy;
   logic [ncr_pkg::CNT_W-1:0]          eff_count;

   assign job_pop   = (state_ff == ST_IDLE) && job_valid;
   assign j_last    = (j_ff == ncr_pkg::J_W'(ncr_pkg::DIM - 1));
   assign k_last    = ((k_ff + 1'b1) == count_ff);
   assign pipe_busy = t1_ff.valid || t2_ff.valid || t3_ff.valid || t4_ff.valid;
   assign eff_count = (int'(centroids_in_use) > ncr_pkg::MAX_CENTROIDS)
                      ? ncr_pkg::CNT_W'(ncr_pkg::MAX_CENTROIDS)
                      : ncr_pkg::CNT_W'(centroids_in_use);

   // Memory addressing: the store row is the scored centroid, or the winner while emitting.
   always_comb begin
      store_we    = job_pop && job.load;
      store_waddr = ncr_pkg::STORE_AW'(int'(job.cidx) * ncr_pkg::DIM + int'(job.didx));
      row         = (state_ff == ST_EMIT) ? best_ff : k_ff[ncr_pkg::K_W-1:0];
      store_raddr = ncr_pkg::STORE_AW'(int'(row) * ncr_pkg::DIM + int'(j_ff));
      norm_raddr  = (state_ff == ST_IDLE) ? job.cidx : k_ff[ncr_pkg::K_W-1:0];
      norm_we     = (state_ff == ST_LOAD_WR);
      norm_wdata  = (job_ff.didx == '0) ? -ncr_pkg::NORM_W'(sq_ff)
                                        : norm_rd_ff - ncr_pkg::NORM_W'(sq_ff);
      emb_we      = job_pop && job.buf_wr;
   end

   // Centroid store.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= job.value;
      end
      store_rd_ff <= store_mem[store_raddr];
   end

   // Negative half norms, updated by read-modify-write: read when a load is taken, written back in ST_LOAD_WR.
   always_ff @(posedge clock) begin
      if (norm_we) begin
         norm_mem[job_ff.cidx] <= norm_wdata;
      end
      norm_rd_ff <= norm_mem[norm_raddr];
   end

   // Embedding buffer.
   always_ff @(posedge clock) begin
      if (emb_we) begin
         emb_mem[job.didx] <= job.value;
      end
      emb_rd_ff <= emb_mem[j_ff];
   end

   // Tags for the reads issued this cycle.
   always_comb begin
      t1_in.valid = (state_ff == ST_SCORE);
      t1_in.first = (j_ff == '0);
      t1_in.last  = j_last;
      t1_in.k     = k_ff[ncr_pkg::K_W-1:0];
      e1_in.valid = (state_ff == ST_EMIT);
      e1_in.last  = j_last;
      e1_in.eod   = job_ff.eod;
      e1_in.j     = j_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               if (job.load) begin
                  state_in = ST_LOAD_WR;
               end else if (job.score) begin
                  state_in = (eff_count == '0) ? ST_EMIT : ST_SCORE;
               end
            end
         end
         ST_LOAD_WR: begin
            state_in = ST_IDLE;
         end
         ST_SCORE: begin
            if (j_last && k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (j_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Multiply-accumulate and scoring pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff.valid <= 1'b0;
         t2_ff.valid <= 1'b0;
         t3_ff.valid <= 1'b0;
         t4_ff.valid <= 1'b0;
         e1_ff.valid <= 1'b0;
      end else begin
         t1_ff       <= t1_in;
         t2_ff       <= t1_ff;
         t3_ff       <= t2_ff;
         t4_ff       <= '{valid: t3_ff.valid && t3_ff.last, first: t3_ff.first,
                          last: t3_ff.last, k: t3_ff.k};
         e1_ff       <= e1_in;
      end
      prod_ff  <= emb_rd_ff * store_rd_ff;
      norm2_ff <= norm_rd_ff;
      norm3_ff <= norm2_ff;
      if (t2_ff.valid) begin
         acc_ff <= t2_ff.first ? ncr_pkg::ACC_W'(prod_ff)
                               : acc_ff + ncr_pkg::ACC_W'(prod_ff);
      end
      if (t3_ff.valid && t3_ff.last) begin
         score_ff <= $signed({acc_ff, 1'b0}) + norm3_ff;
      end
   end

   // Sequencer, winner tracking, document counter and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         doc_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         k_ff          <= '0;
         j_ff          <= '0;
      end else begin
         state_ff <= state_in;

         if (job_pop) begin
            job_ff   <= job;
            count_ff <= eff_count;
            sq_ff    <= job.value * job.value;
            best_ff  <= '0;
            k_ff     <= '0;
            j_ff     <= '0;
         end

         // Walk dimensions within a centroid, then centroids.
         if (state_ff == ST_SCORE) begin
            if (j_last) begin
               j_ff <= '0;
               k_ff <= k_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end else if (state_ff == ST_EMIT) begin
            j_ff <= j_last ? '0 : j_ff + 1'b1;
         end else if (state_ff == ST_DRAIN) begin
            j_ff <= '0;
         end

         // Greatest score wins, the lowest index on ties.
         if (t4_ff.valid && ((t4_ff.k == '0) || (score_ff > best_score_ff))) begin
            best_score_ff <= score_ff;
            best_ff       <= t4_ff.k;
         end

         // One residual element per cycle.
         rsp_strobe_ff <= e1_ff.valid;
         if (e1_ff.valid) begin
            rsp_cluster_id_ff     <= ncr_pkg::CIDX_W'(best_ff);
            rsp_residual_index_ff <= ncr_pkg::DIMX_W'(e1_ff.j);
            rsp_residual_value_ff <= ncr_pkg::RES_W'(emb_rd_ff) - ncr_pkg::RES_W'(store_rd_ff);
            rsp_doc_index_ff      <= doc_ff;
            rsp_last_of_run_ff    <= e1_ff.last;
            if (e1_ff.last && e1_ff.eod) begin
               doc_ff <= doc_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_cluster_id     = rsp_cluster_id_ff;
   assign rsp_residual_index = rsp_residual_index_ff;
   assign rsp_residual_value = rsp_residual_value_ff;
   assign rsp_doc_index      = rsp_doc_index_ff;
   assign rsp_last_of_run    = rsp_last_of_run_ff;

endmodule

`default_nettype wire

@@ hw/rtl/nearest_centroid_residual.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// request   in         start, busy            req_command .. req_end_of_document
// response  out        rsp_strobe             rsp_cluster_id .. rsp_last_of_run
// csr       in         csr_valid, csr_ready   csr_centroids_in_use
//
// An item is taken when start is high and busy is low; up to two items wait in
// the queue, and busy rises only when both places are full.
// The back end takes a centroid load in ST_IDLE and ST_LOAD_WR, an embedding
// element in ST_IDLE alone; a last element scores the centroids in use, one
// multiply-accumulate per cycle through the single read port of the centroid
// store, then emits one residual per cycle. Results leave for one cycle each and
// are never held off. Reset is synchronous and active high; it empties the queue
// and clears the document counter. The tables are undefined until written.

module nearest_centroid_residual (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_command,
   input  wire logic [ncr_pkg::CIDX_W-1:0]         req_centroid_index,
   input  wire logic [ncr_pkg::DIMX_W-1:0]         req_dim_index,
   input  wire logic signed [ncr_pkg::VALUE_W-1:0] req_value,
   input  wire logic                               req_last_element,
   input  wire logic                               req_end_of_document,
   output logic                                    rsp_strobe,
   output logic [ncr_pkg::CIDX_W-1:0]              rsp_cluster_id,
   output logic [ncr_pkg::DIMX_W-1:0]              rsp_residual_index,
   output logic signed [ncr_pkg::RES_W-1:0]        rsp_residual_value,
   output logic [ncr_pkg::DOC_W-1:0]               rsp_doc_index,
   output logic                                    rsp_last_of_run,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [ncr_pkg::CFG_W-1:0]          csr_centroids_in_use
);

   localparam logic [ncr_pkg::CFG_W-1:0] CFG_RESET = ncr_pkg::CFG_W'(8);

   logic [ncr_pkg::CFG_W-1:0] cfg_ff;
   logic                      job_valid;
   ncr_pkg::job_type          job;
   logic                      job_pop;

   // Centroid count register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= csr_centroids_in_use;
      end
   end

   ncr_front u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_centroid_index  (req_centroid_index),
      .req_dim_index       (req_dim_index),
      .req_value           (req_value),
      .req_last_element    (req_last_element),
      .req_end_of_document (req_end_of_document),
      .job_valid           (job_valid),
      .job                 (job),
      .job_pop             (job_pop)
   );

   ncr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (job_valid),
      .job                (job),
      .job_pop            (job_pop),
      .centroids_in_use   (cfg_ff),
      .rsp_strobe         (rsp_strobe),
      .rsp_cluster_id     (rsp_cluster_id),
      .rsp_residual_index (rsp_residual_index),
      .rsp_residual_value (rsp_residual_value),
      .rsp_doc_index      (rsp_doc_index),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

`default_nettype wire

@@ hw/rtl/ncr_checker.sv @@
`default_nettype none

module ncr_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_strobe,
   input wire logic [ncr_pkg::CIDX_W-1:0]   rsp_cluster_id,
   input wire logic [ncr_pkg::DIMX_W-1:0]   rsp_residual_index,
   input wire logic [ncr_pkg::DOC_W-1:0]    rsp_doc_index,
   input wire logic                         rsp_last_of_run
);

   // No result item follows a reset cycle.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result item right after reset");

   // A run of residual items is unbroken and steps through the dimensions.
   a_run_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_run |=>
         rsp_strobe &&
         (rsp_residual_index == ncr_pkg::DIMX_W'($past(rsp_residual_index) + 1'b1)))
      else $error("residual run broken or out of order");

   // Cluster id and document number hold over a run.
   a_run_tags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_run |=> $stable(rsp_cluster_id) && $stable(rsp_doc_index))
      else $error("tags changed within a residual run");

   // A run starts at dimension zero.
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !$past(rsp_strobe) |-> (rsp_residual_index == '0))
      else $error("residual run does not start at dimension zero");

endmodule

bind nearest_centroid_residual ncr_checker u_ncr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_strobe         (rsp_strobe),
   .rsp_cluster_id     (rsp_cluster_id),
   .rsp_residual_index (rsp_residual_index),
   .rsp_doc_index      (rsp_doc_index),
   .rsp_last_of_run    (rsp_last_of_run)
);

`default_nettype wire
